/* rtl/core/sks_pkg.sv */
// Shared types and constants of the sorted store with k-th select.
package sks_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int VALUE_W          = 32;
    localparam int RANK_W           = 9;
    localparam int STORED_W         = 9;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_RANK = 2'd2
    } t_status;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic                      ins;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

    // Where a cell sits relative to the fill level
    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_pos;

endpackage

/* rtl/core/sks_if.sv */
// Request and response channel interfaces.
interface sks_in_if;
    import sks_pkg::*;

    logic                      valid;
    logic                      ready;
    t_opcode                   opcode;
    logic signed [VALUE_W-1:0] new_value;
    logic [RANK_W-1:0]         rank;

    modport source (output valid, output opcode, output new_value, output rank, input ready);
    modport sink   (input valid, input opcode, input new_value, input rank, output ready);
endinterface

interface sks_out_if;
    import sks_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [VALUE_W-1:0] found_value;
    logic [STORED_W-1:0]       stored_count;

    modport source (output valid, output status, output found_value, output stored_count,
                    input ready);
    modport sink   (input valid, input status, input found_value, input stored_count,
                    output ready);
endinterface

/* rtl/core/sks_cell.sv */
// One compare-and-shift cell of the sorted row.
module sks_cell (
    input  logic                               i_clk,
    input  sks_pkg::t_cell_ctrl                i_ctrl,
    input  sks_pkg::t_cell_pos                 i_pos,
    input  logic signed [sks_pkg::VALUE_W-1:0] i_left_value,
    input  logic                               i_left_gt,
    output logic signed [sks_pkg::VALUE_W-1:0] o_value,
    output logic                               o_gt
);
    import sks_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // Held value is above the incoming one: this cell moves right on insert
    assign o_gt    = i_pos.occupied && (r_value > i_ctrl.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins && (o_gt || i_pos.tail)) begin
            n_value = i_left_gt ? i_left_value : i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* rtl/core/sorted_store_kth_select.sv */
// Sorted store with k-th smallest select, built as a row of shift cells.
//
// Requests arrive on i_req (valid/ready): opcode 0 inserts new_value, opcode 1
// asks for the value at 1-based rank. Each request gives exactly one response
// on o_rsp: status, found_value and the fill level after the request.
// Inserts go through a row of CAPACITY compare-and-shift cells: every cell
// compares its value with the new one and either keeps it, takes its left
// neighbour's or takes the new value. A query selects the cell at rank-1 in
// the same cycle. Equal values are kept, the newest after the rest. The
// response follows in the next cycle; one request per cycle while
// the response side keeps taking. The response sits in an output register;
// when the receiver stalls it holds there and i_req.ready drops until it is
// taken. Reset empties the store (fill level zero); cell contents are not
// cleared, as no cell beyond the fill level is ever read. An insert into a
// full store is dropped with status full; a rank of zero or above the fill
// level answers status bad rank with found_value zero.
module sorted_store_kth_select #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sks_in_if.sink     i_req,
    sks_out_if.source  o_rsp
);
    import sks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] r_found;
    logic signed [VALUE_W-1:0] n_found;
    logic [STORED_W-1:0]       r_stored;

    logic                      w_accept;
    logic                      w_full;
    logic [CMP_W-1:0]          w_sel_idx;
    logic signed [VALUE_W-1:0] w_sel_value;
    t_cell_ctrl                w_ctrl;

    logic signed [VALUE_W-1:0] w_value [CAPACITY];
    logic                      w_gt    [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));

    assign w_ctrl.ins   = w_accept && (i_req.opcode == OP_INSERT) && !w_full;
    assign w_ctrl.value = i_req.new_value;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_pos                 w_pos;
        logic signed [VALUE_W-1:0] w_left_value;
        logic                      w_left_gt;

        assign w_pos.occupied = (CNT_W'(gi) < r_count);
        assign w_pos.tail     = (CNT_W'(gi) == r_count);

        if (gi == 0) begin : g_first
            assign w_left_value = '0;
            assign w_left_gt    = 1'b0;
        end else begin : g_rest
            assign w_left_value = w_value[gi-1];
            assign w_left_gt    = w_gt[gi-1];
        end

        sks_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_pos        (w_pos),
            .i_left_value (w_left_value),
            .i_left_gt    (w_left_gt),
            .o_value      (w_value[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    // Rank select across the row
    assign w_sel_idx = CMP_W'(i_req.rank) - CMP_W'(1);

    always_comb begin
        w_sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_sel_idx == CMP_W'(i)) begin
                w_sel_value = w_value[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_found  = '0;
        if (i_req.opcode == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if ((i_req.rank == '0) || (CMP_W'(i_req.rank) > CMP_W'(r_count))) begin
            n_status = ST_BAD_RANK;
        end else begin
            n_found = w_sel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_stored <= STORED_W'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.found_value  = r_found;
    assign o_rsp.stored_count = r_stored;

endmodule

/* bench/tb_sorted_store_kth_select.sv */
// Self-checking regression bench for the sorted store with k-th select.
module tb_sorted_store_kth_select;
    timeunit 1ns;
    timeprecision 1ps;

    import sks_pkg::*;

    localparam int CAP        = CAPACITY_DEFAULT;
    localparam int N_RANDOM   = 1400;
    localparam int QUIET_MAX  = 2000;
    localparam int IDLE_PCT   = 38;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] found;
        logic [STORED_W-1:0]       count;
    } t_answer;

    typedef struct packed {
        t_opcode                   op;
        logic signed [VALUE_W-1:0] val;
        logic [RANK_W-1:0]         rk;
        bit                        typed;
        t_answer                   want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sks_in_if  req_ch ();
    sks_out_if rsp_ch ();

    sorted_store_kth_select uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the store, ascending
    logic signed [VALUE_W-1:0] held [CAP];
    int                        fill;
    t_answer                   awaited_answers [$];

    int  fails;
    int  n_inserts, n_drops, n_misses, n_hits;
    bit  calm;

    // Directed rows; expectations typed in only where obvious
    t_row script [24] = '{
        '{OP_QUERY,  32'sd0,          9'd0,   1'b1, '{ST_BAD_RANK, 32'sd0, 9'd0}},
        '{OP_QUERY,  32'sd0,          9'd1,   1'b1, '{ST_BAD_RANK, 32'sd0, 9'd0}},
        '{OP_QUERY,  32'shDEAD_BEEF,  9'h1FF, 1'b1, '{ST_BAD_RANK, 32'sd0, 9'd0}},
        '{OP_INSERT, V_MAX,           9'h1FF, 1'b1, '{ST_OK,       32'sd0, 9'd1}},
        '{OP_INSERT, V_MIN,           9'd0,   1'b1, '{ST_OK,       32'sd0, 9'd2}},
        '{OP_QUERY,  32'sd0,          9'd1,   1'b1, '{ST_OK,       V_MIN,  9'd2}},
        '{OP_QUERY,  32'shFFFF_FFFF,  9'd2,   1'b1, '{ST_OK,       V_MAX,  9'd2}},
        '{OP_QUERY,  32'sd0,          9'd3,   1'b1, '{ST_BAD_RANK, 32'sd0, 9'd2}},
        '{OP_INSERT, 32'sd0,          9'd5,   1'b1, '{ST_OK,       32'sd0, 9'd3}},
        '{OP_INSERT, -32'sd1,         9'd0,   1'b1, '{ST_OK,       32'sd0, 9'd4}},
        '{OP_INSERT, 32'sd0,          9'd0,   1'b1, '{ST_OK,       32'sd0, 9'd5}},
        '{OP_INSERT, 32'sd1,          9'd100, 1'b1, '{ST_OK,       32'sd0, 9'd6}},
        '{OP_INSERT, V_MAX,           9'd0,   1'b1, '{ST_OK,       32'sd0, 9'd7}},
        '{OP_INSERT, V_MIN,           9'd0,   1'b1, '{ST_OK,       32'sd0, 9'd8}},
        '{OP_QUERY,  32'sh5555_5555,  9'd1,   1'b0, '0},
        '{OP_QUERY,  32'shAAAA_AAAA,  9'd2,   1'b0, '0},
        '{OP_QUERY,  32'sh5555_5555,  9'd3,   1'b0, '0},
        '{OP_QUERY,  32'shAAAA_AAAA,  9'd4,   1'b0, '0},
        '{OP_QUERY,  32'sh5555_5555,  9'd5,   1'b0, '0},
        '{OP_QUERY,  32'shAAAA_AAAA,  9'd6,   1'b0, '0},
        '{OP_QUERY,  32'sh5555_5555,  9'd7,   1'b0, '0},
        '{OP_QUERY,  32'shAAAA_AAAA,  9'd8,   1'b0, '0},
        '{OP_QUERY,  32'sd0,          9'd9,   1'b1, '{ST_BAD_RANK, 32'sd0, 9'd8}},
        '{OP_QUERY,  32'sd0,          9'd256, 1'b1, '{ST_BAD_RANK, 32'sd0, 9'd8}}
    };

    // Applies one request to the shadow store and returns its answer
    function automatic t_answer predict_answer(t_opcode op, logic signed [VALUE_W-1:0] val,
                                               logic [RANK_W-1:0] rk);
        t_answer a;
        int      slot;
        a.status = ST_OK;
        a.found  = '0;
        if (op == OP_INSERT) begin
            if (fill >= CAP) begin
                a.status = ST_FULL;
            end else begin
                slot = fill;
                // equal values stay ahead of the newcomer
                while (slot > 0 && held[slot-1] > val) begin
                    held[slot] = held[slot-1];
                    slot--;
                end
                held[slot] = val;
                fill++;
            end
        end else if (rk == 0 || int'(rk) > fill) begin
            a.status = ST_BAD_RANK;
        end else begin
            a.found = held[rk-1];
        end
        a.count = STORED_W'(fill);
        return a;
    endfunction

    // Called at a rising edge; returns at the edge the request is taken
    task automatic issue(input t_opcode op, input logic signed [VALUE_W-1:0] val,
                         input logic [RANK_W-1:0] rk, input bit typed, input t_answer want);
        t_answer a;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid     <= 1'b0;
            req_ch.opcode    <= t_opcode'($urandom_range(0, 1));
            req_ch.new_value <= $urandom;
            req_ch.rank      <= RANK_W'($urandom);
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.new_value <= val;
        req_ch.rank      <= rk;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        a = predict_answer(op, val, rk);
        if (op == OP_INSERT) n_inserts++;
        awaited_answers.push_back(typed ? want : a);
    endtask

    always @(posedge i_clk) begin
        if (calm) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
                $error("response with no request outstanding");
                fails++;
            end else begin
                w = awaited_answers.pop_front();
                case (w.status)
                    ST_FULL:     n_drops++;
                    ST_BAD_RANK: n_misses++;
                    default:     n_hits++;
                endcase
                if (rsp_ch.status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, rsp_ch.status);
                    fails++;
                end
                if (rsp_ch.found_value !== w.found) begin
                    $error("found_value: expected %0d, got %0d", w.found, rsp_ch.found_value);
                    fails++;
                end
                if (rsp_ch.stored_count !== w.count) begin
                    $error("stored_count: expected %0d, got %0d", w.count,
                           rsp_ch.stored_count);
                    fails++;
                end
            end
        end
    end

    // Watchdog: stop if neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no request or response moved for %0d cycles", QUIET_MAX);
        $display("sorted_store_kth_select regression: fail");
        $finish;
    end

    initial begin
        t_opcode                   op;
        logic signed [VALUE_W-1:0] v;
        logic [RANK_W-1:0]         rk;
        int                        sel;
        int                        ins_pct;

        fails = 0;
        n_inserts = 0;
        n_drops = 0;
        n_misses = 0;
        n_hits = 0;
        calm = 1'b0;
        fill = 0;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OP_INSERT;
        req_ch.new_value <= '0;
        req_ch.rank      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            issue(script[i].op, script[i].val, script[i].rk, script[i].typed, script[i].want);
        end

        // Store only grows, so this fills it and then keeps hitting the full case
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 500 && n < 700);
            ins_pct = (fill < CAP) ? 35 : 25;
            op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_QUERY;

            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                v = $urandom;
            end else if (sel < 70) begin
                v = int'($urandom_range(0, 8)) - 4;   // dense duplicates
            end else if (sel < 80) begin
                case ($urandom_range(0, 3))
                    0:       v = V_MIN;
                    1:       v = V_MAX;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end else if (fill > 0) begin
                v = held[$urandom_range(0, fill - 1)];
            end else begin
                v = $urandom;
            end

            sel = $urandom_range(0, 99);
            if (sel < 70 && fill > 0) begin
                rk = RANK_W'($urandom_range(1, fill));
            end else if (sel < 80) begin
                rk = '0;
            end else if (sel < 90) begin
                rk = RANK_W'($urandom_range(fill + 1, 511));
            end else begin
                rk = RANK_W'($urandom);
            end

            issue(op, v, rk, 1'b0, '0);
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests: %0d inserts, store filled to %0d of %0d",
                 n_drops + n_misses + n_hits, n_inserts, fill, CAP);
        $display("answers seen: %0d ok, %0d dropped on a full store, %0d rank misses",
                 n_hits, n_drops, n_misses);
        if (fails == 0) begin
            $display("sorted_store_kth_select regression: pass");
        end else begin
            $display("sorted_store_kth_select regression: fail");
        end
        $finish;
    end

endmodule

/* sorted_store_kth_select.f */
rtl/core/sks_pkg.sv
rtl/core/sks_if.sv
rtl/core/sks_cell.sv
rtl/core/sorted_store_kth_select.sv
bench/tb_sorted_store_kth_select.sv
